FILE: sv/salwc_pkg.sv
`default_nettype none
package salwc_pkg;

  // cache geometry
  localparam int WAYS         = 2;
  localparam int INDEX_BITS   = 6;
  localparam int OFFSET_BITS  = 2;
  localparam int ADDRESS_BITS = 32;

  localparam int SETS      = 1 << INDEX_BITS;
  localparam int TAG_BITS  = ADDRESS_BITS - INDEX_BITS - OFFSET_BITS;
  localparam int WAY_BITS  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int DCNT_BITS = $clog2(WAYS + 1);

  // field widths
  localparam int MODE_BITS  = 2;
  localparam int ADDR_W     = 32;
  localparam int STAMP_BITS = 31;
  localparam int COST_BITS  = 8;
  localparam int CYC_BITS   = 9;
  localparam int CNT_BITS   = 32;

  localparam int IN_BITS       = ADDR_W + STAMP_BITS;
  localparam int IN_TDATA_BITS = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS      = 2 + CYC_BITS + 4 * CNT_BITS;
  localparam int OUT_TDATA_BITS = ((OUT_BITS + 7) / 8) * 8;

  // access modes
  localparam logic [MODE_BITS-1:0] MODE_READ  = 2'd0;
  localparam logic [MODE_BITS-1:0] MODE_WRITE = 2'd1;
  localparam logic [MODE_BITS-1:0] MODE_FLUSH = 2'd2;

  // config register indexes and reset values
  localparam int CFG_INDEX_BITS = 2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_HIT_COST        = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_READ_MISS_COST  = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_WRITE_BACK_COST = 2'd2;

  localparam logic [COST_BITS-1:0] HIT_COST_RST        = 8'd5;
  localparam logic [COST_BITS-1:0] READ_MISS_COST_RST  = 8'd21;
  localparam logic [COST_BITS-1:0] WRITE_BACK_COST_RST = 8'd2;

  typedef logic [INDEX_BITS-1:0] set_t;

  typedef struct packed {
    logic                  valid;
    logic                  dirty;
    logic [TAG_BITS-1:0]   tag;
    logic [STAMP_BITS-1:0] stamp;
  } line_t;

  typedef line_t [WAYS-1:0] row_t;

endpackage
`default_nettype wire

FILE: sv/salwc_row_store.sv
`default_nettype none
// One row per set, all ways side by side. Rows never written read as the
// reset row (invalid, clean, tag zero, stamp = set index).
module salwc_row_store (
  input  logic                clk,
  input  logic                rst,
  input  logic                re,
  input  salwc_pkg::set_t     raddr,
  input  logic                we,
  input  salwc_pkg::set_t     waddr,
  input  salwc_pkg::row_t     wdata,
  output salwc_pkg::row_t     rdata
);
  import salwc_pkg::*;

  row_t            mem [SETS];
  logic [SETS-1:0] known;
  row_t            raw;
  logic            known_q;
  set_t            addr_q;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      raw    <= mem[raddr];
      addr_q <= raddr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      known   <= '0;
      known_q <= 1'b0;
    end else begin
      if (re) begin
        known_q <= known[raddr];
      end
      if (we) begin
        known[waddr] <= 1'b1;
      end
    end
  end

  always_comb begin
    rdata = raw;
    if (!known_q) begin
      for (int w = 0; w < WAYS; w++) begin
        rdata[w].valid = 1'b0;
        rdata[w].dirty = 1'b0;
        rdata[w].tag   = '0;
        rdata[w].stamp = STAMP_BITS'(addr_q);
      end
    end
  end

endmodule
`default_nettype wire

FILE: sv/set_assoc_lru_writeback_cache_tags_top.sv
`default_nettype none
// Tag store of a 2-way set-associative write-back cache (64 sets) with
// least-recently-used replacement by recency stamp. Each transaction on the
// slave stream is one access: s_tuser carries the mode (read, write, flush),
// s_tdata the byte address and stamp. Exactly one result transaction comes
// back per access, carrying hit and write-back flags, the cycles charged and
// the four running totals after the access. A read or write reads the set
// from the row RAM, then writes the updated row back; a flush sweeps every
// set through the same RAM, one set per cycle. A new access is taken once
// the previous one is finished and the result register is empty or being
// drained. Reset needs no clearing pass: a per-set flag marks rows that
// were never written and those read as the reset contents. Cost registers
// are written through cfg_we / cfg_index / cfg_data, by the user only while
// the block is idle; the block does not enforce this. Index 3 is ignored.
module set_assoc_lru_writeback_cache_tags_top (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       cfg_we,
  input  logic [salwc_pkg::CFG_INDEX_BITS-1:0]       cfg_index,
  input  logic [salwc_pkg::COST_BITS-1:0]            cfg_data,
  input  logic                                       s_tvalid,
  output logic                                       s_tready,
  // address [31:0], stamp [62:32], zero pad
  input  logic [salwc_pkg::IN_TDATA_BITS-1:0]        s_tdata,
  // mode [1:0]
  input  logic [salwc_pkg::MODE_BITS-1:0]            s_tuser,
  output logic                                       m_tvalid,
  input  logic                                       m_tready,
  // hit [0], wrote_back [1], cycles_added [10:2], total_cycles [42:11],
  // hit_count [74:43], miss_count [106:75], write_back_count [138:107], pad
  output logic [salwc_pkg::OUT_TDATA_BITS-1:0]       m_tdata
);
  import salwc_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_LOOK  = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;

  // cost registers
  logic [COST_BITS-1:0] hit_cost, read_miss_cost, write_back_cost;

  // control
  logic [1:0] state, state_next;
  logic       accept;
  set_t       sweep;
  logic       flush_any;

  // access held for the lookup cycle
  logic [MODE_BITS-1:0]  mode_q;
  set_t                  set_q;
  logic [TAG_BITS-1:0]   tag_q;
  logic [STAMP_BITS-1:0] stamp_q;

  // running totals
  logic [CNT_BITS-1:0] cyc_total, hit_total, miss_total, wb_total;
  logic [CNT_BITS-1:0] cyc_total_next, hit_total_next, miss_total_next, wb_total_next;

  // result register
  logic                      out_valid;
  logic [OUT_TDATA_BITS-1:0] out_data;
  logic                      out_load;
  logic                      res_hit, res_wb;
  logic [CYC_BITS-1:0]       res_cyc;

  // input fields
  logic [ADDR_W-1:0]     in_addr;
  logic [STAMP_BITS-1:0] in_stamp;
  set_t                  in_set;

  // row RAM ports
  logic re, we;
  set_t raddr, waddr;
  row_t rdata, wdata;

  // lookup datapath
  logic [WAYS-1:0]       hit_vec;
  logic                  hit_any;
  logic [WAY_BITS-1:0]   hit_way, victim;
  logic [STAMP_BITS-1:0] low;
  row_t                  upd_row, clean_row;
  logic                  victim_wb;
  logic [CYC_BITS-1:0]   miss_cyc;
  logic [DCNT_BITS-1:0]  dcnt;

  assign in_addr  = s_tdata[ADDR_W-1:0];
  assign in_stamp = s_tdata[ADDR_W +: STAMP_BITS];
  assign in_set   = in_addr[OFFSET_BITS +: INDEX_BITS];

  assign s_tready = (state == ST_IDLE) && (!out_valid || m_tready);
  assign accept   = s_tvalid && s_tready;
  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

  // read the set on accept; a flush starts at set 0 and reads one ahead
  assign re    = accept || (state == ST_FLUSH);
  assign raddr = accept ? ((s_tuser == MODE_FLUSH) ? set_t'(0) : in_set)
                        : set_t'(sweep + 1'b1);

  salwc_row_store u_rows (
    .clk   (clk),
    .rst   (rst),
    .re    (re),
    .raddr (raddr),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .rdata (rdata)
  );

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      hit_cost        <= HIT_COST_RST;
      read_miss_cost  <= READ_MISS_COST_RST;
      write_back_cost <= WRITE_BACK_COST_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_HIT_COST:        hit_cost        <= cfg_data;
        CFG_READ_MISS_COST:  read_miss_cost  <= cfg_data;
        CFG_WRITE_BACK_COST: write_back_cost <= cfg_data;
        default: ;
      endcase
    end
  end

  // hit search, LRU victim, updated row
  always_comb begin
    hit_any = 1'b0;
    hit_way = '0;
    for (int w = 0; w < WAYS; w++) begin
      hit_vec[w] = rdata[w].valid && (rdata[w].tag == tag_q);
    end
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (hit_vec[w]) begin
        hit_any = 1'b1;
        hit_way = WAY_BITS'(w);
      end
    end

    // lowest stamp, lowest way on ties
    victim = '0;
    low    = rdata[0].stamp;
    for (int w = 1; w < WAYS; w++) begin
      if (rdata[w].stamp < low) begin
        low    = rdata[w].stamp;
        victim = WAY_BITS'(w);
      end
    end
    victim_wb = rdata[victim].valid && rdata[victim].dirty;

    miss_cyc = (mode_q == MODE_WRITE) ? CYC_BITS'(hit_cost) : CYC_BITS'(read_miss_cost);
    if (victim_wb) begin
      miss_cyc = miss_cyc + CYC_BITS'(write_back_cost);
    end

    upd_row = rdata;
    if (hit_any) begin
      upd_row[hit_way].stamp = stamp_q;
      if (mode_q == MODE_WRITE) begin
        upd_row[hit_way].dirty = 1'b1;
      end
    end else begin
      upd_row[victim].valid = 1'b1;
      upd_row[victim].dirty = (mode_q == MODE_WRITE);
      upd_row[victim].tag   = tag_q;
      upd_row[victim].stamp = stamp_q;
    end
  end

  // flush: dirty lines become invalid and clean, tag and stamp kept
  always_comb begin
    clean_row = rdata;
    dcnt      = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (rdata[w].dirty) begin
        clean_row[w].valid = 1'b0;
        clean_row[w].dirty = 1'b0;
        dcnt = dcnt + 1'b1;
      end
    end
  end

  // sequencer
  always_comb begin
    state_next      = state;
    we              = 1'b0;
    waddr           = set_q;
    wdata           = upd_row;
    out_load        = 1'b0;
    res_hit         = 1'b0;
    res_wb          = 1'b0;
    res_cyc         = '0;
    cyc_total_next  = cyc_total;
    hit_total_next  = hit_total;
    miss_total_next = miss_total;
    wb_total_next   = wb_total;

    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = (s_tuser == MODE_FLUSH) ? ST_FLUSH : ST_LOOK;
        end
      end
      ST_LOOK: begin
        out_load   = 1'b1;
        state_next = ST_IDLE;
        if (mode_q == MODE_READ || mode_q == MODE_WRITE) begin
          we = 1'b1;
          if (hit_any) begin
            res_hit        = 1'b1;
            res_cyc        = CYC_BITS'(hit_cost);
            hit_total_next = hit_total + 1'b1;
          end else begin
            res_wb          = victim_wb;
            res_cyc         = miss_cyc;
            miss_total_next = miss_total + 1'b1;
            if (victim_wb) begin
              wb_total_next = wb_total + 1'b1;
            end
          end
          cyc_total_next = cyc_total + CNT_BITS'(res_cyc);
        end
      end
      ST_FLUSH: begin
        we            = 1'b1;
        waddr         = sweep;
        wdata         = clean_row;
        wb_total_next = wb_total + CNT_BITS'(dcnt);
        if (sweep == set_t'(SETS - 1)) begin
          out_load   = 1'b1;
          res_wb     = flush_any || (dcnt != '0);
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      sweep      <= '0;
      flush_any  <= 1'b0;
      cyc_total  <= '0;
      hit_total  <= '0;
      miss_total <= '0;
      wb_total   <= '0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      cyc_total  <= cyc_total_next;
      hit_total  <= hit_total_next;
      miss_total <= miss_total_next;
      wb_total   <= wb_total_next;
      if (accept) begin
        sweep     <= '0;
        flush_any <= 1'b0;
      end else if (state == ST_FLUSH) begin
        sweep     <= sweep + 1'b1;
        flush_any <= flush_any || (dcnt != '0);
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_q  <= s_tuser;
      set_q   <= in_set;
      tag_q   <= in_addr[ADDRESS_BITS-1 : OFFSET_BITS + INDEX_BITS];
      stamp_q <= in_stamp;
    end
    if (out_load) begin
      out_data <= OUT_TDATA_BITS'({wb_total_next, miss_total_next, hit_total_next,
                                   cyc_total_next, res_cyc, res_wb, res_hit});
    end
  end

endmodule
`default_nettype wire

FILE: sim/set_assoc_lru_writeback_cache_tags_top_tb.sv
module set_assoc_lru_writeback_cache_tags_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import salwc_pkg::*;

  // mode 3 is not a defined access: the block must answer it with no state change
  localparam logic [MODE_BITS-1:0] MODE_NONE = 2'd3;
  // register index past the cost registers, writes are dropped
  localparam logic [CFG_INDEX_BITS-1:0] CFG_UNUSED = 2'd3;

  localparam logic [STAMP_BITS-1:0] STAMP_MAX = '1;
  localparam logic [COST_BITS-1:0]  COST_MAX  = '1;
  localparam logic [COST_BITS-1:0]  COST_MIN  = '0;

  // result bit positions on m_tdata, lowest field first
  localparam int POS_CYC   = 2;
  localparam int POS_TOTAL = POS_CYC + CYC_BITS;
  localparam int POS_HITS  = POS_TOTAL + CNT_BITS;
  localparam int POS_MISS  = POS_HITS + CNT_BITS;
  localparam int POS_WBS   = POS_MISS + CNT_BITS;

  // a flush sweep plus stalls and gaps stays far below this limit
  localparam int QUIET_LIMIT  = 5000;
  localparam int RANDOM_ITEMS = 700;
  localparam int PHASES       = 4;

  logic                      clk;
  logic                      rst;
  logic                      cfg_we;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [COST_BITS-1:0]      cfg_data;
  logic                      s_tvalid;
  logic                      s_tready;
  // address [31:0], stamp [62:32], zero pad
  logic [IN_TDATA_BITS-1:0]  s_tdata;
  // mode [1:0]
  logic [MODE_BITS-1:0]      s_tuser;
  logic                      m_tvalid;
  logic                      m_tready;
  // hit [0], wrote_back [1], cycles_added [10:2], total_cycles [42:11],
  // hit_count [74:43], miss_count [106:75], write_back_count [138:107], pad
  logic [OUT_TDATA_BITS-1:0] m_tdata;

  set_assoc_lru_writeback_cache_tags_top uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  // one result transaction as the block should produce it
  typedef struct {
    logic                 hit;
    logic                 wrote_back;
    logic [CYC_BITS-1:0]  cycles_added;
    logic [CNT_BITS-1:0]  total_cycles;
    logic [CNT_BITS-1:0]  hit_count;
    logic [CNT_BITS-1:0]  miss_count;
    logic [CNT_BITS-1:0]  write_back_count;
  } access_outcome_t;

  // ---------------------------------------------------------------------------
  // Shadow tag store: our own copy of the cache state and cost registers.
  // ---------------------------------------------------------------------------
  logic                  ln_valid [WAYS][SETS];
  logic                  ln_dirty [WAYS][SETS];
  logic [TAG_BITS-1:0]   ln_tag   [WAYS][SETS];
  logic [STAMP_BITS-1:0] ln_stamp [WAYS][SETS];
  logic [CNT_BITS-1:0]   cycle_sum, hit_sum, miss_sum, write_back_sum;
  logic [COST_BITS-1:0]  hit_cost, read_miss_cost, write_back_cost;

  access_outcome_t outcome_fifo[$];
  int              mismatch_count;
  bit              idle_on;
  int              quiet_cycles;

  function automatic void reset_shadow();
    for (int w = 0; w < WAYS; w++) begin
      for (int i = 0; i < SETS; i++) begin
        ln_valid[w][i] = 1'b0;
        ln_dirty[w][i] = 1'b0;
        ln_tag[w][i]   = '0;
        ln_stamp[w][i] = STAMP_BITS'(i);   // reset stamp is the set index
      end
    end
    cycle_sum       = '0;
    hit_sum         = '0;
    miss_sum        = '0;
    write_back_sum  = '0;
    hit_cost        = HIT_COST_RST;
    read_miss_cost  = READ_MISS_COST_RST;
    write_back_cost = WRITE_BACK_COST_RST;
  endfunction

  // Apply one access to the shadow store and return the result it must give.
  function automatic access_outcome_t predict_access(logic [MODE_BITS-1:0] mode,
                                                     logic [ADDR_W-1:0] addr,
                                                     logic [STAMP_BITS-1:0] stamp);
    access_outcome_t     o;
    set_t                set_idx;
    logic [TAG_BITS-1:0] tag;
    int                  victim;
    logic [CYC_BITS-1:0] cyc;
    bit                  wb;
    bit                  found;
    o.hit   = 1'b0;
    wb      = 1'b0;
    found   = 1'b0;
    cyc     = '0;
    set_idx = addr[OFFSET_BITS +: INDEX_BITS];
    tag     = addr[ADDRESS_BITS-1 : OFFSET_BITS+INDEX_BITS];
    case (mode)
      MODE_FLUSH: begin
        // every dirty line is written back and dropped; tag and stamp stay
        for (int w = 0; w < WAYS; w++) begin
          for (int i = 0; i < SETS; i++) begin
            if (ln_dirty[w][i]) begin
              write_back_sum++;
              ln_dirty[w][i] = 1'b0;
              ln_valid[w][i] = 1'b0;
              wb = 1'b1;
            end
          end
        end
      end
      MODE_READ, MODE_WRITE: begin
        for (int w = 0; w < WAYS; w++) begin
          if (!found && ln_valid[w][set_idx] && ln_tag[w][set_idx] == tag) begin
            found = 1'b1;
            ln_stamp[w][set_idx] = stamp;
            if (mode == MODE_WRITE) ln_dirty[w][set_idx] = 1'b1;
          end
        end
        if (found) begin
          o.hit = 1'b1;
          hit_sum++;
          cyc = CYC_BITS'(hit_cost);
        end else begin
          miss_sum++;
          // oldest stamp loses, lowest way on a tie
          victim = 0;
          for (int w = 1; w < WAYS; w++) begin
            if (ln_stamp[w][set_idx] < ln_stamp[victim][set_idx]) victim = w;
          end
          cyc = (mode == MODE_WRITE) ? CYC_BITS'(hit_cost) : CYC_BITS'(read_miss_cost);
          if (ln_valid[victim][set_idx] && ln_dirty[victim][set_idx]) begin
            wb = 1'b1;
            write_back_sum++;
            cyc = cyc + CYC_BITS'(write_back_cost);
          end
          ln_valid[victim][set_idx] = 1'b1;
          ln_dirty[victim][set_idx] = (mode == MODE_WRITE);
          ln_tag[victim][set_idx]   = tag;
          ln_stamp[victim][set_idx] = stamp;
        end
        cycle_sum = cycle_sum + CNT_BITS'(cyc);
      end
      default: ;   // undefined mode: nothing changes
    endcase
    o.wrote_back       = wb;
    o.cycles_added     = cyc;
    o.total_cycles     = cycle_sum;
    o.hit_count        = hit_sum;
    o.miss_count       = miss_sum;
    o.write_back_count = write_back_sum;
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, watchdog
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ends the run if no transaction on either side for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result side: random back-pressure, one stall draw per transaction.
  // ---------------------------------------------------------------------------
  initial begin
    int stall;
    m_tready = 1'b0;
    wait (rst === 1'b0);
    @(negedge clk);
    forever begin
      stall = idle_on ? $urandom_range(0, 4) : 0;
      if (stall > 0) begin
        m_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready = 1'b1;
      do @(posedge clk); while (!m_tvalid);
      @(negedge clk);
    end
  end

  task automatic check_field(string name, logic [CNT_BITS-1:0] want,
                             logic [CNT_BITS-1:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatch_count++;
    end
  endtask

  // Compare every accepted result against the oldest outstanding prediction.
  always @(posedge clk) begin
    access_outcome_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (outcome_fifo.size() == 0) begin
        $error("result transaction with no access outstanding: 0x%0h", m_tdata);
        mismatch_count++;
      end else begin
        want = outcome_fifo.pop_front();
        check_field("hit", CNT_BITS'(want.hit), CNT_BITS'(m_tdata[0]));
        check_field("wrote_back", CNT_BITS'(want.wrote_back), CNT_BITS'(m_tdata[1]));
        check_field("cycles_added", CNT_BITS'(want.cycles_added),
                    CNT_BITS'(m_tdata[POS_CYC +: CYC_BITS]));
        check_field("total_cycles", want.total_cycles, m_tdata[POS_TOTAL +: CNT_BITS]);
        check_field("hit_count", want.hit_count, m_tdata[POS_HITS +: CNT_BITS]);
        check_field("miss_count", want.miss_count, m_tdata[POS_MISS +: CNT_BITS]);
        check_field("write_back_count", want.write_back_count,
                    m_tdata[POS_WBS +: CNT_BITS]);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Access side. All tasks start and end on a falling edge.
  // ---------------------------------------------------------------------------

  // One access transaction; valid stays high afterwards so back-to-back
  // accesses need no dead cycle. The prediction is made at acceptance.
  task automatic send_access(logic [MODE_BITS-1:0] mode, logic [ADDR_W-1:0] addr,
                             logic [STAMP_BITS-1:0] stamp);
    int              gap;
    access_outcome_t predicted;
    gap = idle_on ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tuser                     = mode;
    s_tdata                     = '0;
    s_tdata[0 +: ADDR_W]        = addr;
    s_tdata[ADDR_W +: STAMP_BITS] = stamp;
    s_tvalid                    = 1'b1;
    do @(posedge clk); while (!s_tready);
    predicted = predict_access(mode, addr, stamp);
    outcome_fifo.insert(outcome_fifo.size(), predicted);
    @(negedge clk);
  endtask

  // Stop sending and hold off until every outstanding result is back.
  task automatic drain_results();
    s_tvalid = 1'b0;
    while (outcome_fifo.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Register write; only called with the block drained.
  task automatic write_cost(logic [CFG_INDEX_BITS-1:0] idx, logic [COST_BITS-1:0] val);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_we    = 1'b0;
    case (idx)
      CFG_HIT_COST:        hit_cost        = val;
      CFG_READ_MISS_COST:  read_miss_cost  = val;
      CFG_WRITE_BACK_COST: write_back_cost = val;
      default: ;
    endcase
  endtask

  task automatic set_costs(logic [COST_BITS-1:0] h, logic [COST_BITS-1:0] r,
                           logic [COST_BITS-1:0] w);
    drain_results();
    write_cost(CFG_HIT_COST, h);
    write_cost(CFG_READ_MISS_COST, r);
    write_cost(CFG_WRITE_BACK_COST, w);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset costs: tie on equal reset stamps, hit on another offset, write miss,
  // write hit, fill of an invalid way, dirty victim eviction, clean eviction.
  task automatic test_lru_basics();
    send_access(MODE_READ,  32'h0000_0000, 31'd0);
    send_access(MODE_READ,  32'h0000_0003, 31'd1);
    send_access(MODE_WRITE, 32'hFFFF_FFFF, STAMP_MAX);
    send_access(MODE_WRITE, 32'hFFFF_FFFC, 31'd100);
    send_access(MODE_READ,  32'h0000_00FC, 31'd1);
    send_access(MODE_WRITE, 32'h3000_00FC, 31'd0);
    send_access(MODE_READ,  32'h4000_00FC, 31'd5);   // evicts the dirty way 1
    send_access(MODE_READ,  32'h3000_00FC, 31'd6);
    send_access(MODE_READ,  32'hFFFF_FFFC, 31'd7);
  endtask

  // Flush with dirty lines, flush with none, then the flushed line must miss.
  task automatic test_flush();
    send_access(MODE_FLUSH, 32'h0000_0000, 31'd0);
    send_access(MODE_FLUSH, $urandom, STAMP_MAX);
    send_access(MODE_READ,  32'hFFFF_FFFC, 31'd8);
  endtask

  // Undefined mode between a write and a read of the same line, then a flush.
  task automatic test_undefined_mode();
    send_access(MODE_WRITE, 32'h1234_5678, 31'd9);
    send_access(MODE_NONE,  32'h1234_5678, 31'd10);
    send_access(MODE_READ,  32'h1234_5678, 31'd11);
    send_access(MODE_FLUSH, 32'h1234_5678, 31'd12);
  endtask

  // All-ones costs give the widest cycles_added; all-zero costs give none.
  task automatic test_cost_extremes();
    set_costs(COST_MAX, COST_MAX, COST_MAX);
    send_access(MODE_WRITE, 32'hABCD_0010, 31'd20);
    send_access(MODE_WRITE, 32'hBBCD_0010, 31'd21);
    send_access(MODE_READ,  32'hCBCD_0010, 31'd22);   // dirty victim, cycles_added = 510
    set_costs(COST_MIN, COST_MIN, COST_MIN);
    send_access(MODE_READ,  32'hABCD_0010, 31'd23);
    send_access(MODE_WRITE, 32'hCBCD_0010, 31'd24);
  endtask

  // A write to the spare index must leave the costs alone.
  task automatic test_unused_register();
    set_costs(HIT_COST_RST, READ_MISS_COST_RST, WRITE_BACK_COST_RST);
    write_cost(CFG_UNUSED, COST_MAX);
    send_access(MODE_READ,  32'h5555_5554, 31'd30);
    send_access(MODE_WRITE, 32'hAAAA_AAA8, 31'd31);
  endtask

  // Mostly a small pool of tags over a few sets, so lines hit, age and get
  // evicted dirty; stamps mostly climb, with random and extreme ones mixed in.
  // Now and then fully random addresses, flushes and undefined accesses.
  task automatic test_random_traffic();
    logic [TAG_BITS-1:0]   tag_pool [6];
    set_t                  set_pool [6];
    logic [STAMP_BITS-1:0] stamp_clock;
    logic [MODE_BITS-1:0]  mode;
    logic [ADDR_W-1:0]     addr;
    logic [STAMP_BITS-1:0] stamp;
    int                    pick;
    tag_pool[0] = '0;
    tag_pool[1] = '1;
    set_pool[0] = '0;
    set_pool[1] = '1;
    for (int i = 2; i < 6; i++) begin
      tag_pool[i] = TAG_BITS'($urandom);
      set_pool[i] = INDEX_BITS'($urandom);
    end
    stamp_clock = 31'd1000;
    for (int ph = 0; ph < PHASES; ph++) begin
      // every phase starts from a drained block with new costs
      case (ph)
        1:       set_costs(COST_MAX, COST_MIN, COST_MAX);
        2:       set_costs(COST_MIN, COST_MAX, COST_MIN);
        default: set_costs(COST_BITS'($urandom), COST_BITS'($urandom),
                           COST_BITS'($urandom));
      endcase
      for (int n = 0; n < RANDOM_ITEMS / PHASES; n++) begin
        if (n % 40 == 0) idle_on = ($urandom_range(0, 3) != 0);
        pick = $urandom_range(0, 99);
        if (pick < 3)       mode = MODE_FLUSH;
        else if (pick < 4)  mode = MODE_NONE;
        else if (pick < 50) mode = MODE_READ;
        else                mode = MODE_WRITE;
        if ($urandom_range(0, 99) < 85)
          addr = {tag_pool[$urandom_range(0, 5)], set_pool[$urandom_range(0, 5)],
                  OFFSET_BITS'($urandom)};
        else
          addr = $urandom;
        pick = $urandom_range(0, 99);
        if (pick < 88) begin
          stamp_clock = stamp_clock + STAMP_BITS'($urandom_range(1, 3));
          stamp = stamp_clock;
        end else if (pick < 96) begin
          stamp = STAMP_BITS'($urandom);
        end else begin
          stamp = pick[0] ? STAMP_MAX : '0;
        end
        send_access(mode, addr, stamp);
      end
    end
    idle_on = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst            = 1'b1;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    s_tvalid       = 1'b0;
    s_tdata        = '0;
    s_tuser        = MODE_READ;
    mismatch_count = 0;
    idle_on        = 1'b1;
    reset_shadow();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_lru_basics();
    test_flush();
    test_undefined_mode();
    test_cost_extremes();
    test_unused_register();
    test_random_traffic();

    drain_results();
    // longest access is a flush sweep, give it that much to show anything stray
    repeat (80) @(posedge clk);
    if (outcome_fifo.size() != 0) begin
      $error("%0d results never arrived", outcome_fifo.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/salwc_pkg.sv
sv/salwc_row_store.sv
sv/set_assoc_lru_writeback_cache_tags_top.sv
sim/set_assoc_lru_writeback_cache_tags_top_tb.sv
